// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Needs clk and rst_n in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while reset is low.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
// Same-cycle implication built on the macro above.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  `CHK_ASSERT(lbl, (ante) |-> (cons), msg)
// Next-cycle implication built on the first macro.
`define CHK_NEXT(lbl, ante, cons, msg) \
  `CHK_ASSERT(lbl, (ante) |=> (cons), msg)
`endif

// ===== hdl/ronh_pkg.sv =====
// Package for the ray versus obstacle nearest-hit unit.
// Types, widths, micro-op table and codes; no dependencies.
`default_nettype none
package ronh_pkg;

  localparam int COORD_W   = 16;
  localparam int SLOT_W    = 4;
  localparam int SLOT_SPAN = 16;
  localparam int OPW       = COORD_W + 2;
  localparam int PROD_W    = 2 * OPW;
  localparam int ACC_W     = PROD_W + 2;
  localparam int LAMBDA_BITS = 15;
  localparam int LEN_W     = 16;
  localparam int DEF_MAX_OBSTACLES = 16;
  localparam logic [LEN_W-1:0] LAMBDA_ONE      = 16'd32768;
  localparam logic [LEN_W-1:0] FULL_LENGTH_RST = 16'd400;
  localparam logic             CFG_IDX_FULL_LENGTH = 1'b0;
  localparam logic             OPC_WRITE = 1'b0;
  localparam logic             OPC_CAST  = 1'b1;

  // input word field offsets
  localparam int IN_DATA_W = 136;
  localparam int OFS_SLOT  = 0;
  localparam int OFS_OX    = 4;
  localparam int OFS_OY    = 20;
  localparam int OFS_OW    = 36;
  localparam int OFS_OH    = 52;
  localparam int OFS_RECT  = 68;
  localparam int OFS_ACT   = 69;
  localparam int OFS_RX    = 70;
  localparam int OFS_RY    = 86;
  localparam int OFS_DX    = 102;
  localparam int OFS_DY    = 118;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_LOAD, ST_MUL, ST_DRAIN, ST_NORM, ST_TEST, ST_DIV, ST_FINAL
  } state_t;

  typedef enum logic [2:0] {
    KIND_TOP, KIND_BOTTOM, KIND_LEFT, KIND_RIGHT, KIND_SEG
  } kind_t;

  typedef enum logic [3:0] {
    OP_ZERO, OP_ONE, OP_PX, OP_PY, OP_NB, OP_NR, OP_DX, OP_DY, OP_OW, OP_OH
  } opsel_t;

  typedef struct packed {
    opsel_t opa;
    opsel_t opb;
    logic   neg;
  } uop_t;

  typedef struct packed {
    logic       vld;
    logic [2:0] step;
    logic       neg;
  } mac_ctl_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] n1;
    logic signed [ACC_W-1:0] d1;
    logic signed [ACC_W-1:0] n2;
    logic signed [ACC_W-1:0] d2;
  } cand_t;

  // Steps 0/1 form n1, 2/3 d1, 4/5 n2, 6/7 d2; each as a sum of two products.
  function automatic uop_t uop(kind_t k, logic [2:0] s);
    opsel_t n1s, d1s, pa, pb, qa, qb, da, db;
    uop_t   u;
    n1s = OP_PY; d1s = OP_DY; pa = OP_PX; pb = OP_DY; qa = OP_PY; qb = OP_DX;
    da = OP_DY; db = OP_OW;
    unique case (k)
      KIND_TOP: begin
        n1s = OP_PY; d1s = OP_DY; pa = OP_PX; pb = OP_DY; qa = OP_PY; qb = OP_DX;
        da = OP_DY; db = OP_OW;
      end
      KIND_BOTTOM: begin
        n1s = OP_NB; d1s = OP_DY; pa = OP_PX; pb = OP_DY; qa = OP_NB; qb = OP_DX;
        da = OP_DY; db = OP_OW;
      end
      KIND_LEFT: begin
        n1s = OP_PX; d1s = OP_DX; pa = OP_PY; pb = OP_DX; qa = OP_PX; qb = OP_DY;
        da = OP_DX; db = OP_OH;
      end
      KIND_RIGHT: begin
        n1s = OP_NR; d1s = OP_DX; pa = OP_PY; pb = OP_DX; qa = OP_NR; qb = OP_DY;
        da = OP_DX; db = OP_OH;
      end
      default: begin
      end
    endcase
    u = '{opa: OP_ZERO, opb: OP_ZERO, neg: 1'b0};
    if (k == KIND_SEG) begin
      unique case (s)
        3'd0: u = '{opa: OP_PX, opb: OP_OH, neg: 1'b0};
        3'd1: u = '{opa: OP_PY, opb: OP_OW, neg: 1'b1};
        3'd2: u = '{opa: OP_DX, opb: OP_OH, neg: 1'b0};
        3'd3: u = '{opa: OP_DY, opb: OP_OW, neg: 1'b1};
        3'd4: u = '{opa: OP_DY, opb: OP_PX, neg: 1'b0};
        3'd5: u = '{opa: OP_DX, opb: OP_PY, neg: 1'b1};
        3'd6: u = '{opa: OP_DX, opb: OP_OH, neg: 1'b0};
        3'd7: u = '{opa: OP_DY, opb: OP_OW, neg: 1'b1};
        default: u = '{opa: OP_ZERO, opb: OP_ZERO, neg: 1'b0};
      endcase
    end else begin
      unique case (s)
        3'd0: u = '{opa: n1s, opb: OP_ONE, neg: 1'b0};
        3'd2: u = '{opa: d1s, opb: OP_ONE, neg: 1'b0};
        3'd4: u = '{opa: pa, opb: pb, neg: 1'b1};
        3'd5: u = '{opa: qa, opb: qb, neg: 1'b0};
        3'd6: u = '{opa: da, opb: db, neg: 1'b0};
        default: u = '{opa: OP_ZERO, opb: OP_ZERO, neg: 1'b0};
      endcase
    end
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ronh_div.sv =====
// Restoring fraction divider: floor(num * 2^15 / den) for num < den.
// One quotient bit per cycle. Uses ronh_pkg.
`default_nettype none
module ronh_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [ronh_pkg::ACC_W-1:0] num,
  input  wire logic [ronh_pkg::ACC_W-1:0] den,
  output logic                            done,
  output logic [ronh_pkg::LAMBDA_BITS-1:0] quo
);
  import ronh_pkg::*;

  logic             busy_r;
  logic [3:0]       cnt_r;
  logic [ACC_W-1:0] rem_r;
  logic [ACC_W-1:0] den_r;
  logic [LAMBDA_BITS-1:0] quo_r;
  logic             done_r;
  logic [ACC_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(LAMBDA_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? ACC_W'(rem_sh - {1'b0, den_r}) : rem_sh[ACC_W-1:0];
      quo_r <= {quo_r[LAMBDA_BITS-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

// ===== hdl/ronh_mac.sv =====
// Shared multiply-accumulate unit: one product a cycle, registered, then summed
// in pairs into the four candidate terms. Uses ronh_pkg.
`default_nettype none
module ronh_mac (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ronh_pkg::mac_ctl_t              ctl,
  input  wire logic signed [ronh_pkg::OPW-1:0] opa,
  input  wire logic signed [ronh_pkg::OPW-1:0] opb,
  output ronh_pkg::cand_t                      cand
);
  import ronh_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  mac_ctl_t                 ctl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  sum;
  cand_t                    cand_r;

  assign term = ctl_r.neg ? -ACC_W'(prod_r) : ACC_W'(prod_r);
  assign sum  = acc_r + term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    if (ctl_r.vld) begin
      if (!ctl_r.step[0]) begin
        acc_r <= term;
      end else begin
        unique case (ctl_r.step[2:1])
          2'd0: cand_r.n1 <= sum;
          2'd1: cand_r.d1 <= sum;
          2'd2: cand_r.n2 <= sum;
          2'd3: cand_r.d2 <= sum;
          default: cand_r.n1 <= sum;
        endcase
      end
    end
  end

  assign cand = cand_r;
endmodule
`default_nettype wire

// ===== hdl/ray_obstacle_nearest_hit_unit.sv =====
// Ray versus obstacle table, nearest hit.
// A cast walks the table: it skips inactive slots, loads each active slot and,
// per tested edge (4 for a rectangle, 1 for a segment), forms the candidate
// terms on the shared multiplier path, normalises and tests them, and runs the
// divider when the test passes; the smallest fraction is issued as the result.
// Synchronous active-low reset clears control and flags and sets full_length to 400.
`default_nettype none
module ray_obstacle_nearest_hit_unit #(
  parameter int MAX_OBSTACLES = ronh_pkg::DEF_MAX_OBSTACLES
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // slot, obstacle_x, obstacle_y, obstacle_w, obstacle_h, obstacle_is_rect,
  // obstacle_active, ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y, pad
  input  wire logic [ronh_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // hit_fraction, ray_length
  output logic [ronh_pkg::OUT_DATA_W-1:0]         out_tdata,
  // hit
  output logic                                    out_tuser,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [2:0]                         cfg_paddr,
  input  wire logic [31:0]                        cfg_pwdata,
  output logic [31:0]                             cfg_prdata,
  output logic                                    cfg_pready
);
  import ronh_pkg::*;

  localparam int DEPTH = (MAX_OBSTACLES < SLOT_SPAN) ? MAX_OBSTACLES : SLOT_SPAN;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // table: corner/extent in plain registers, flags cleared by reset
  logic signed [COORD_W-1:0] cx_mem [DEPTH];
  logic signed [COORD_W-1:0] cy_mem [DEPTH];
  logic signed [COORD_W-1:0] ew_mem [DEPTH];
  logic signed [COORD_W-1:0] eh_mem [DEPTH];
  logic [DEPTH-1:0]          rect_r;
  logic [DEPTH-1:0]          act_r;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [IDX_W-1:0] idx;
  kind_t            kind_r;
  logic [2:0]       step_r;
  logic [LEN_W-1:0] best_r;
  logic [LEN_W-1:0] full_length_r;
  logic signed [COORD_W-1:0] rx_r, ry_r, dx_r, dy_r;
  logic signed [OPW-1:0]     px_r, py_r, nb_r, nr_r, ow_r, oh_r;
  logic signed [ACC_W-1:0]   n1a_r, d1a_r, n2a_r, d2a_r;
  logic                      z1_r, z2_r;
  logic [LEN_W-1:0]          frac_r, len_r;
  logic                      hit_r, out_valid_r;

  logic in_acc, cast_acc, write_acc, cfg_wr, last_kind, pass, out_free, div_start, div_done;
  logic [LAMBDA_BITS-1:0] quo;
  logic signed [OPW-1:0]  opa, opb;
  logic [2*LEN_W-1:0]     len_prod;
  uop_t      u;
  mac_ctl_t  mac_ctl;
  cand_t     cand;
  logic [SLOT_W-1:0] slot;

  assign in_acc    = in_tvalid && in_tready;
  assign cast_acc  = in_acc && (in_tuser == OPC_CAST);
  assign write_acc = in_acc && (in_tuser == OPC_WRITE);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign slot      = in_tdata[OFS_SLOT +: SLOT_W];
  assign idx       = idx_r[IDX_W-1:0];
  assign last_kind = (kind_r == KIND_RIGHT) || (kind_r == KIND_SEG);
  assign out_free  = !out_valid_r || out_tready;
  assign pass = !z1_r && !z2_r && !n1a_r[ACC_W-1] && (n1a_r < d1a_r)
             && !n2a_r[ACC_W-1] && (n2a_r <= d2a_r);
  assign u = uop(kind_r, step_r);
  assign len_prod = full_length_r * best_r;

  function automatic logic signed [OPW-1:0] pick(opsel_t s,
      logic signed [OPW-1:0] px, logic signed [OPW-1:0] py, logic signed [OPW-1:0] nb,
      logic signed [OPW-1:0] nr, logic signed [OPW-1:0] ow, logic signed [OPW-1:0] oh,
      logic signed [COORD_W-1:0] dx, logic signed [COORD_W-1:0] dy);
    logic signed [OPW-1:0] v;
    unique case (s)
      OP_ONE:  v = OPW'(1);
      OP_PX:   v = px;
      OP_PY:   v = py;
      OP_NB:   v = nb;
      OP_NR:   v = nr;
      OP_DX:   v = OPW'(dx);
      OP_DY:   v = OPW'(dy);
      OP_OW:   v = ow;
      OP_OH:   v = oh;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign opa = pick(u.opa, px_r, py_r, nb_r, nr_r, ow_r, oh_r, dx_r, dy_r);
  assign opb = pick(u.opb, px_r, py_r, nb_r, nr_r, ow_r, oh_r, dx_r, dy_r);

  ronh_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .opa  (opa),
    .opb  (opb),
    .cand (cand)
  );

  ronh_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (n1a_r),
    .den  (d1a_r),
    .done (div_done),
    .quo  (quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (cast_acc) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (idx_r == CNT_W'(DEPTH)) begin
          state_nxt = ST_FINAL;
        end else if (act_r[idx]) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD:  state_nxt = ST_MUL;
      ST_MUL:   if (step_r == 3'd7) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_NORM;
      ST_NORM:  state_nxt = ST_TEST;
      ST_TEST: begin
        if (pass) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = last_kind ? ST_SCAN : ST_MUL;
        end
      end
      ST_DIV:   if (div_done) state_nxt = last_kind ? ST_SCAN : ST_MUL;
      ST_FINAL: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    mac_ctl   = '{vld: (state_r == ST_MUL), step: step_r, neg: u.neg};
    div_start = (state_r == ST_TEST) && pass;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // table writes: ignore slots beyond the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_r <= '0;
      act_r  <= '0;
    end else if (write_acc && (9'(slot) < 9'(MAX_OBSTACLES))) begin
      rect_r[slot[IDX_W-1:0]] <= in_tdata[OFS_RECT];
      act_r[slot[IDX_W-1:0]]  <= in_tdata[OFS_ACT];
    end
  end

  always_ff @(posedge clk) begin
    if (write_acc && (9'(slot) < 9'(MAX_OBSTACLES))) begin
      cx_mem[slot[IDX_W-1:0]] <= in_tdata[OFS_OX +: COORD_W];
      cy_mem[slot[IDX_W-1:0]] <= in_tdata[OFS_OY +: COORD_W];
      ew_mem[slot[IDX_W-1:0]] <= in_tdata[OFS_OW +: COORD_W];
      eh_mem[slot[IDX_W-1:0]] <= in_tdata[OFS_OH +: COORD_W];
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      step_r <= '0;
      kind_r <= KIND_TOP;
      best_r <= LAMBDA_ONE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cast_acc) begin
            idx_r  <= '0;
            best_r <= LAMBDA_ONE;
          end
        end
        ST_SCAN: begin
          if (idx_r != CNT_W'(DEPTH) && !act_r[idx]) idx_r <= idx_r + 1'b1;
        end
        ST_LOAD: begin
          idx_r  <= idx_r + 1'b1;
          step_r <= '0;
          kind_r <= rect_r[idx] ? KIND_TOP : KIND_SEG;
        end
        ST_MUL: step_r <= step_r + 3'd1;
        ST_TEST: begin
          if (!pass && !last_kind) begin
            kind_r <= kind_t'(kind_r + 3'd1);
            step_r <= '0;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (LEN_W'(quo) < best_r) best_r <= LEN_W'(quo);
            if (!last_kind) begin
              kind_r <= kind_t'(kind_r + 3'd1);
              step_r <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ray and obstacle operands, sign normalisation of the candidate
  always_ff @(posedge clk) begin
    if (cast_acc) begin
      rx_r <= in_tdata[OFS_RX +: COORD_W];
      ry_r <= in_tdata[OFS_RY +: COORD_W];
      dx_r <= in_tdata[OFS_DX +: COORD_W];
      dy_r <= in_tdata[OFS_DY +: COORD_W];
    end
    if (state_r == ST_LOAD) begin
      px_r <= OPW'(cx_mem[idx]) - OPW'(rx_r);
      py_r <= OPW'(cy_mem[idx]) - OPW'(ry_r);
      nr_r <= OPW'(cx_mem[idx]) + OPW'(ew_mem[idx]) - OPW'(rx_r);
      nb_r <= OPW'(cy_mem[idx]) + OPW'(eh_mem[idx]) - OPW'(ry_r);
      ow_r <= OPW'(ew_mem[idx]);
      oh_r <= OPW'(eh_mem[idx]);
    end
    if (state_r == ST_NORM) begin
      z1_r  <= (cand.d1 == '0);
      z2_r  <= (cand.d2 == '0);
      n1a_r <= cand.d1[ACC_W-1] ? -cand.n1 : cand.n1;
      d1a_r <= cand.d1[ACC_W-1] ? -cand.d1 : cand.d1;
      n2a_r <= cand.d2[ACC_W-1] ? -cand.n2 : cand.n2;
      d2a_r <= cand.d2[ACC_W-1] ? -cand.d2 : cand.d2;
    end
  end

  // result register: hold until taken, load once the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINAL && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINAL && out_free) begin
      frac_r <= best_r;
      len_r  <= len_prod[LAMBDA_BITS +: LEN_W];
      hit_r  <= !best_r[LEN_W-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {len_r, frac_r};
  assign out_tuser  = hit_r;

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_length_r <= FULL_LENGTH_RST;
    end else if (cfg_wr && cfg_paddr[2] == CFG_IDX_FULL_LENGTH) begin
      full_length_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_FULL_LENGTH) ? 32'(full_length_r) : '0;

endmodule
`default_nettype wire

// ===== hdl/ronh_chk.sv =====
// Port-level checker for the nearest-hit unit, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ronh_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [31:0]  out_tdata,
  input wire logic         out_tuser
);
  `CHK_IMPLY(a_hit_flag, out_tvalid, out_tuser == (out_tdata[15:0] != 16'h8000), "hit flag mismatch")
  `CHK_IMPLY(a_frac_range, out_tvalid && out_tdata[15], out_tdata[15:0] == 16'h8000, "fraction above one")
  `CHK_NEXT(a_busy_after_cast, in_tvalid && in_tready && in_tuser, !in_tready, "ready during cast")
  `CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "word dropped")
endmodule

bind ray_obstacle_nearest_hit_unit ronh_chk u_ronh_chk (.*);
`default_nettype wire

// ===== tb/sv/ray_obstacle_nearest_hit_checker.sv =====
// Checker for the ray versus obstacle nearest-hit unit: watches both streams and the APB port.
// Keeps its own obstacle table and range register, predicts each cast result and compares it.
// Depends on ronh_pkg for widths and field offsets.
`default_nettype none
module ray_obstacle_nearest_hit_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [ronh_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                           in_tuser,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [ronh_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           out_tuser,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [2:0]                     cfg_paddr,
  input  wire logic [31:0]                    cfg_pwdata,
  input  wire logic                           cfg_pready,
  output int                                  fail_count,
  output int                                  pending_hits,
  output int                                  casts_seen,
  output int                                  hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import ronh_pkg::*;

  typedef struct packed {
    logic [15:0] fraction;
    logic [15:0] length;
    logic        hit;
  } cast_result_t;

  localparam int NSLOT = DEF_MAX_OBSTACLES;

  longint    corner_x [NSLOT];
  longint    corner_y [NSLOT];
  longint    extent_x [NSLOT];
  longint    extent_y [NSLOT];
  logic      is_rect  [NSLOT];
  logic      active   [NSLOT];
  logic [15:0] range_reg;
  cast_result_t expected_casts [$];

  function automatic longint field16(logic [IN_DATA_W-1:0] w, int ofs);
    logic signed [15:0] v;
    v = w[ofs +: 16];
    return longint'(v);
  endfunction

  // Floor of n/d in Q1.15 for 0 <= n < d, or LAMBDA_ONE when the edge misses.
  function automatic int edge_lambda(longint n1, longint d1, longint n2, longint d2);
    longint r;
    int     q;
    if (d1 == 0 || d2 == 0) return 32768;
    if (d1 < 0) begin n1 = -n1; d1 = -d1; end
    if (d2 < 0) begin n2 = -n2; d2 = -d2; end
    if (n1 < 0 || n1 >= d1 || n2 < 0 || n2 > d2) return 32768;
    r = n1;
    q = 0;
    for (int i = 0; i < LAMBDA_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d1) begin
        r -= d1;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic cast_result_t nearest_hit(logic [IN_DATA_W-1:0] w);
    longint rx, ry, dx, dy, px, py, ow, oh, nb, nr;
    int best, c;
    cast_result_t res;
    rx = field16(w, OFS_RX); ry = field16(w, OFS_RY);
    dx = field16(w, OFS_DX); dy = field16(w, OFS_DY);
    best = 32768;
    for (int i = 0; i < NSLOT; i++) begin
      if (!active[i]) continue;
      px = corner_x[i] - rx; py = corner_y[i] - ry;
      ow = extent_x[i]; oh = extent_y[i];
      if (is_rect[i]) begin
        nb = py + oh; nr = px + ow;
        c = edge_lambda(py, dy, -px * dy + py * dx, dy * ow); if (c < best) best = c;
        c = edge_lambda(nb, dy, -px * dy + nb * dx, dy * ow); if (c < best) best = c;
        c = edge_lambda(px, dx, -py * dx + px * dy, dx * oh); if (c < best) best = c;
        c = edge_lambda(nr, dx, -py * dx + nr * dy, dx * oh); if (c < best) best = c;
      end else begin
        c = edge_lambda(px * oh - py * ow, dx * oh - dy * ow, dy * px - dx * py,
                        dx * oh - dy * ow);
        if (c < best) best = c;
      end
    end
    res.fraction = best[15:0];
    res.length   = 16'((longint'(range_reg) * best) >> LAMBDA_BITS);
    res.hit      = best < 32768;
    return res;
  endfunction

  always @(posedge clk) begin
    cast_result_t exp_r, got;
    logic [SLOT_W-1:0] s;
    if (!rst_n) begin
      range_reg <= FULL_LENGTH_RST;
      for (int i = 0; i < NSLOT; i++) begin
        active[i] = 1'b0;
        is_rect[i] = 1'b0;
      end
      expected_casts.delete();
      fail_count = 0; casts_seen = 0; hits_seen = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && cfg_paddr[2] == CFG_IDX_FULL_LENGTH)
        range_reg <= cfg_pwdata[15:0];
      if (in_tvalid && in_tready) begin
        if (in_tuser == OPC_WRITE) begin
          s = in_tdata[OFS_SLOT +: SLOT_W];
          corner_x[s] = field16(in_tdata, OFS_OX);
          corner_y[s] = field16(in_tdata, OFS_OY);
          extent_x[s] = field16(in_tdata, OFS_OW);
          extent_y[s] = field16(in_tdata, OFS_OH);
          is_rect[s]  = in_tdata[OFS_RECT];
          active[s]   = in_tdata[OFS_ACT];
        end else begin
          expected_casts.push_back(nearest_hit(in_tdata));
          casts_seen++;
        end
      end
      if (out_tvalid && out_tready) begin
        got.fraction = out_tdata[15:0];
        got.length   = out_tdata[31:16];
        got.hit      = out_tuser;
        if (got.hit) hits_seen++;
        if (expected_casts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_r = expected_casts.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: frac %0d/%0d len %0d/%0d hit %0b/%0b (exp/got)",
                       exp_r.fraction, got.fraction, exp_r.length, got.length,
                       exp_r.hit, got.hit);
          end
        end
      end
    end
    pending_hits = expected_casts.size();
  end
endmodule
`default_nettype wire

// ===== tb/sv/ray_obstacle_nearest_hit_unit_tb.sv =====
// Top of the nearest-hit testbench: clock, reset, stimulus and verdict.
// Depends on ronh_pkg, ray_obstacle_nearest_hit_unit and ray_obstacle_nearest_hit_checker.
`default_nettype none
module ray_obstacle_nearest_hit_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ronh_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = OPC_WRITE;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int fail_count, pending_hits, casts_seen, hits_seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ray_obstacle_nearest_hit_unit dut (.*);

  ray_obstacle_nearest_hit_checker checker_i (.*);

  // Receiver: hold ready low for a wait drawn at random for each waiting result
  // word; some phases never stall.
  bit quiet_sink = 1'b0;
  int sink_wait = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait = $urandom_range(0, 4);
    end else if (quiet_sink) begin
      out_tready <= 1'b1;
    end else begin
      if (out_tvalid && out_tready) sink_wait = $urandom_range(0, 4);
      else if (out_tvalid && sink_wait > 0) sink_wait--;
      out_tready <= (sink_wait == 0);
    end
  end

  // Hold off all stimulus until every prediction has been matched.
  task automatic drain_casts();
    @(posedge clk);
    while (pending_hits != 0) @(posedge clk);
  endtask

  // APB write to full_length; setup then access phase.
  task automatic write_range(logic [15:0] v);
    drain_casts();
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {CFG_IDX_FULL_LENGTH, 2'b00}; cfg_pwdata <= {16'h0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Send one word, after a gap drawn at random unless gaps are off.
  task automatic send_word(logic opc, logic [IN_DATA_W-1:0] w, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 4);
    repeat (gap) @(posedge clk);
    in_tvalid <= 1'b1; in_tuser <= opc; in_tdata <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic put_obstacle(int s, logic [15:0] x, logic [15:0] y, logic [15:0] w,
                              logic [15:0] h, logic rect, logic act);
    logic [IN_DATA_W-1:0] d;
    d = IN_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    d[OFS_SLOT +: SLOT_W] = s[3:0];
    d[OFS_OX +: 16] = x; d[OFS_OY +: 16] = y;
    d[OFS_OW +: 16] = w; d[OFS_OH +: 16] = h;
    d[OFS_RECT] = rect; d[OFS_ACT] = act;
    send_word(OPC_WRITE, d);
  endtask

  task automatic cast_ray(logic [15:0] rx, logic [15:0] ry, logic [15:0] dx,
                          logic [15:0] dy);
    logic [IN_DATA_W-1:0] d;
    d = IN_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    d[OFS_RX +: 16] = rx; d[OFS_RY +: 16] = ry;
    d[OFS_DX +: 16] = dx; d[OFS_DY +: 16] = dy;
    send_word(OPC_CAST, d);
  endtask

  // Mostly small coordinates so rays meet obstacles; now and then a full-range value.
  function automatic logic [15:0] coord();
    if ($urandom_range(0, 7) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(0, 2047)) - 1024);
  endfunction

  initial begin
    int s;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, then rectangle edges, segments and degenerate shapes.
    cast_ray(16'h0000, 16'h0000, 16'h0100, 16'h0100);
    put_obstacle(0, 16'h0040, 16'hFFC0, 16'h0040, 16'h0080, 1'b1, 1'b1);
    cast_ray(16'h0000, 16'h0000, 16'h0100, 16'h0000);   // zero dy: vertical edges only
    cast_ray(16'h0060, 16'h0100, 16'h0000, 16'hFE00);   // zero dx: horizontal edges only
    cast_ray(16'h0000, 16'h0000, 16'h0040, 16'h0000);   // stops exactly at the edge
    put_obstacle(1, 16'h0100, 16'h0000, 16'h0000, 16'h0100, 1'b0, 1'b1);
    cast_ray(16'h0000, 16'h0080, 16'h0200, 16'h0000);   // segment with zero dx extent
    cast_ray(16'h0000, 16'h0000, 16'h0000, 16'h0100);   // parallel to the segment
    cast_ray(16'h0000, 16'h0100, 16'h0200, 16'h0000);   // grazes the segment end
    put_obstacle(2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1); // point
    put_obstacle(3, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b1, 1'b1);
    put_obstacle(4, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 1'b1);
    cast_ray(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    cast_ray(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    cast_ray(16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF);
    put_obstacle(15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    cast_ray(16'h0000, 16'h0000, 16'h0000, 16'h0000);   // null ray
    write_range(16'd0);
    cast_ray(16'h0000, 16'h0000, 16'h0100, 16'h0000);
    write_range(16'hFFFF);
    cast_ray(16'h0000, 16'h0000, 16'h0100, 16'h0000);
    cast_ray(16'h0000, 16'h0080, 16'h0200, 16'h0000);

    // Random: table rewrites mixed with casts; stall-free and pressure phases between.
    for (int n = 0; n < 200; n++) begin
      if (n == 60) quiet_sink = 1'b1;
      if (n == 100) begin
        quiet_sink = 1'b0;
        write_range(16'($urandom_range(1, 65534)));
      end
      if (n == 150) write_range(FULL_LENGTH_RST);
      if (n % 40 == 39) drain_casts();
      if ($urandom_range(0, 2) == 0) begin
        s = $urandom_range(0, DEF_MAX_OBSTACLES - 1);
        put_obstacle(s, coord(), coord(), coord(), coord(), 1'($urandom()),
                     $urandom_range(0, 3) != 0);
      end else begin
        cast_ray(coord(), coord(), coord(), coord());
      end
    end

    drain_casts();
    repeat (2100) @(posedge clk);
    $display("covered %0d casts (%0d hits) over rectangles, segments and degenerate shapes,",
             casts_seen, hits_seen);
    $display("with several ray lengths and random stalls on both streams");
    if (fail_count == 0 && pending_hits == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
